@@ rtl/slms_pkg.sv @@
package slms_pkg;

    // Default sizes of the column store and the shifted window.
    localparam int STORE_DEPTH_DEF    = 256;
    localparam int WINDOW_COLUMNS_DEF = 32;

    // The row count is fixed by the 8-bit column format.
    localparam int ROW_COUNT = 8;
    localparam int ROW_W     = 3;

    localparam int COL_W    = 8;
    localparam int ADDR_W   = 8;
    localparam int OFFSET_W = 8;
    localparam int FRAME_W  = 8;
    localparam int DWELL_W  = 16;

    localparam logic [OFFSET_W-1:0] SCROLL_POSITIONS_RST = 8'd106;
    localparam logic [FRAME_W-1:0]  FRAMES_PER_STEP_RST  = 8'd10;
    localparam logic [DWELL_W-1:0]  DWELL_TICKS_RST      = 16'd1000;

    localparam logic [ROW_COUNT-1:0] ROW_ALL_OFF = 8'hff;

    // Input operation codes.
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Configuration port.
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_SCROLL_POSITIONS = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_FRAMES_PER_STEP  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_DWELL_TICKS      = 2'd2;

    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] column_address;
        logic [COL_W-1:0]  column_bits;
    } t_in_item;

    typedef struct packed {
        logic                 serial_data;
        logic                 shift_clock;
        logic                 latch;
        logic [ROW_COUNT-1:0] row_drive;
        logic [OFFSET_W-1:0]  scroll_offset;
    } t_out_item;

endpackage

@@ rtl/scrolling_led_matrix_scanner.sv @@
// Tick path: the store read happens at the accept edge into the read stage, and the
// result then moves to the output register when it is free; write beats give no result.
// Throughput: one beat per cycle while the output is not stalled.
// Reset: synchronous, active low. After reset the column store is swept to zero,
// one entry per cycle, over every entry; input ready stays low during the sweep
// while configuration writes are taken as usual.
module scrolling_led_matrix_scanner
    import slms_pkg::*;
#(
    parameter int STORE_DEPTH    = STORE_DEPTH_DEF,
    parameter int WINDOW_COLUMNS = WINDOW_COLUMNS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_data,

    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_data,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int AW        = $clog2(STORE_DEPTH);
    localparam int BW        = $clog2(WINDOW_COLUMNS);
    localparam int SUM_MAX   = (1 << OFFSET_W) - 1 + WINDOW_COLUMNS - 1;
    localparam int SUM_W     = $clog2(SUM_MAX + 1);
    localparam int MOD_STEPS = SUM_MAX / STORE_DEPTH;

    // Configuration registers.
    logic [OFFSET_W-1:0] r_scroll_positions;
    logic [FRAME_W-1:0]  r_frames_per_step;
    logic [DWELL_W-1:0]  r_dwell_ticks;

    // Scan state.
    logic [OFFSET_W-1:0] r_offset, n_offset;
    logic [FRAME_W-1:0]  r_frame, n_frame;
    logic [ROW_W-1:0]    r_row, n_row;
    logic [BW-1:0]       r_bit_index, n_bit_index;
    logic                r_clock_phase, n_clock_phase;
    logic                r_display, n_display;
    logic [DWELL_W-1:0]  r_dwell, n_dwell;

    // Clearing sweep.
    logic                r_clr_active;
    logic [AW-1:0]       r_clr_addr;

    // Column store.
    logic [COL_W-1:0]    mem [STORE_DEPTH];
    logic [COL_W-1:0]    r_rd_data;
    logic [SUM_W-1:0]    rd_sum;
    logic [AW-1:0]       rd_addr;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [COL_W-1:0]    wr_data;

    // Read stage and output register.
    logic                r_s1_valid;
    logic                r_s1_shift;
    logic [ROW_W-1:0]    r_s1_row;
    t_out_item           r_s1_item;
    t_out_item           s1_out;
    logic                r_out_valid;
    t_out_item           r_out_item;

    logic                out_free;
    logic                s1_move;
    logic                in_acc;
    logic                tick_acc;
    logic                write_acc;
    logic                cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;
    logic [DWELL_W-1:0]  dwell_limit;
    logic [DWELL_W-1:0]  dwell_inc;
    logic [FRAME_W-1:0]  frame_inc;
    logic [OFFSET_W-1:0] offset_inc;
    t_out_item           tick_item;

    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_move    = r_s1_valid && out_free;
    assign o_in_ready = !r_clr_active && (!r_s1_valid || out_free);
    assign in_acc     = i_in_valid && o_in_ready;
    assign tick_acc   = in_acc && (i_in_data.op == OP_TICK);
    assign write_acc  = in_acc && (i_in_data.op == OP_WRITE);

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

    // ---------------------------------------------------------------
    // Configuration port
    // ---------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        case (cfg_idx)
            REG_SCROLL_POSITIONS: prdata = PDATA_W'(r_scroll_positions);
            REG_FRAMES_PER_STEP:  prdata = PDATA_W'(r_frames_per_step);
            REG_DWELL_TICKS:      prdata = PDATA_W'(r_dwell_ticks);
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scroll_positions <= SCROLL_POSITIONS_RST;
            r_frames_per_step  <= FRAMES_PER_STEP_RST;
            r_dwell_ticks      <= DWELL_TICKS_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_SCROLL_POSITIONS: r_scroll_positions <= pwdata[OFFSET_W-1:0];
                REG_FRAMES_PER_STEP:  r_frames_per_step  <= pwdata[FRAME_W-1:0];
                REG_DWELL_TICKS:      r_dwell_ticks      <= pwdata[DWELL_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Column store: one write port shared by the sweep and write beats,
    // one registered read port used by tick beats.
    // ---------------------------------------------------------------
    always_comb begin
        rd_sum = SUM_W'(r_offset) + SUM_W'(r_bit_index);
        // The window wraps around the end of the store.
        for (int k = 0; k < MOD_STEPS; k++) begin
            if (rd_sum >= SUM_W'(STORE_DEPTH)) begin
                rd_sum = rd_sum - SUM_W'(STORE_DEPTH);
            end
        end
        rd_addr = AW'(rd_sum);
    end

    always_comb begin
        if (r_clr_active) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else begin
            wr_en   = write_acc && (32'(i_in_data.column_address) < STORE_DEPTH);
            wr_addr = AW'(i_in_data.column_address);
            wr_data = i_in_data.column_bits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (tick_acc) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else if (r_clr_active) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(STORE_DEPTH - 1)) begin
                r_clr_active <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Scan sequencer, advanced once per tick beat.
    // ---------------------------------------------------------------
    assign dwell_limit = (r_dwell_ticks == '0) ? DWELL_W'(1) : r_dwell_ticks;
    assign dwell_inc   = r_dwell + 1'b1;
    assign frame_inc   = r_frame + 1'b1;
    assign offset_inc  = r_offset + 1'b1;

    always_comb begin
        n_offset      = r_offset;
        n_frame       = r_frame;
        n_row         = r_row;
        n_bit_index   = r_bit_index;
        n_clock_phase = r_clock_phase;
        n_display     = r_display;
        n_dwell       = r_dwell;

        if (r_display) begin
            n_dwell = dwell_inc;
            if (dwell_inc >= dwell_limit) begin
                n_dwell   = '0;
                n_display = 1'b0;
                n_row     = r_row + 1'b1;
                if (r_row == ROW_W'(ROW_COUNT - 1)) begin
                    n_frame = frame_inc;
                    if (frame_inc >= r_frames_per_step) begin
                        n_frame  = '0;
                        n_offset = (offset_inc >= r_scroll_positions) ? '0 : offset_inc;
                    end
                end
            end
        end else if (!r_clock_phase) begin
            n_clock_phase = 1'b1;
        end else begin
            n_clock_phase = 1'b0;
            n_bit_index   = r_bit_index + 1'b1;
            if (r_bit_index == BW'(WINDOW_COLUMNS - 1)) begin
                n_bit_index = '0;
                n_display   = 1'b1;
                n_dwell     = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset      <= '0;
            r_frame       <= '0;
            r_row         <= '0;
            r_bit_index   <= '0;
            r_clock_phase <= 1'b0;
            r_display     <= 1'b0;
            r_dwell       <= '0;
        end else if (tick_acc) begin
            r_offset      <= n_offset;
            r_frame       <= n_frame;
            r_row         <= n_row;
            r_bit_index   <= n_bit_index;
            r_clock_phase <= n_clock_phase;
            r_display     <= n_display;
            r_dwell       <= n_dwell;
        end
    end

    // Pin levels known at accept time; the pixel bit is filled in after the read.
    always_comb begin
        tick_item.serial_data   = 1'b0;
        tick_item.scroll_offset = r_offset;
        if (r_display) begin
            tick_item.shift_clock = 1'b0;
            tick_item.latch       = 1'b1;
            tick_item.row_drive   = ~(ROW_COUNT'(1) << r_row);
        end else begin
            tick_item.shift_clock = r_clock_phase;
            tick_item.latch       = 1'b0;
            tick_item.row_drive   = ROW_ALL_OFF;
        end
    end

    // ---------------------------------------------------------------
    // Read stage and output register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (tick_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_acc) begin
            r_s1_shift <= !r_display;
            r_s1_row   <= r_row;
            r_s1_item  <= tick_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Bit 7 of a column is the top row.
    always_comb begin
        s1_out             = r_s1_item;
        s1_out.serial_data = r_s1_shift && r_rd_data[ROW_W'(ROW_COUNT - 1) - r_s1_row];
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_item <= s1_out;
        end
    end

endmodule
